@@ src/rom3_pkg.sv @@
// shared types and constants of the range outlier median-of-3 filter
package rom3_pkg;

  localparam int unsigned DistW = 12;
  localparam int unsigned ChanW = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned RingLen = 3;
  localparam int unsigned NumChannelsDef = 5;

  localparam logic [DistW-1:0] MaxDistReset = 12'd400;
  localparam logic [DistW-1:0] MaxJumpReset = 12'd30;

  typedef enum logic [1:0] {
    StMedian = 2'd0,
    StFill   = 2'd1,
    StRange  = 2'd2,
    StJump   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMaxDist = 1'b0,
    RegMaxJump = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [DistW-1:0] raw_distance;
  } in_t;

  typedef struct packed {
    logic [ChanW-1:0] channel_out;
    logic [DistW-1:0] filtered_distance;
    status_e          status;
  } out_t;

  typedef logic [RingLen-1:0][DistW-1:0] ring_t;

  // history of one channel
  typedef struct packed {
    logic [DistW-1:0] last_good;
    logic             last_good_valid;
    logic [1:0]       ring_ptr;
    logic [1:0]       fill_cnt;
    ring_t            slots;
  } chan_state_t;

endpackage

@@ src/rom3_chan_state.sv @@
// per-channel history registers: last good value, ring pointer, fill count, ring slots
module rom3_chan_state #(
  parameter int unsigned NumChannels = rom3_pkg::NumChannelsDef,
  parameter int unsigned IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IdxW-1:0]       rd_idx_i,
  output rom3_pkg::chan_state_t rd_state_o,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_idx_i,
  input  rom3_pkg::chan_state_t wr_state_i
);

  logic [rom3_pkg::DistW-1:0] last_good_q [NumChannels];
  logic [NumChannels-1:0]     lg_valid_q;
  logic [1:0]                 ring_ptr_q  [NumChannels];
  logic [1:0]                 fill_cnt_q  [NumChannels];
  rom3_pkg::ring_t            slots_q     [NumChannels];

  always_comb begin
    rd_state_o.last_good       = last_good_q[rd_idx_i];
    rd_state_o.last_good_valid = lg_valid_q[rd_idx_i];
    rd_state_o.ring_ptr        = ring_ptr_q[rd_idx_i];
    rd_state_o.fill_cnt        = fill_cnt_q[rd_idx_i];
    rd_state_o.slots           = slots_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_valid_q <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        last_good_q[i] <= '0;
        ring_ptr_q[i]  <= '0;
        fill_cnt_q[i]  <= '0;
      end
    end else if (wr_en_i) begin
      last_good_q[wr_idx_i] <= wr_state_i.last_good;
      lg_valid_q[wr_idx_i]  <= wr_state_i.last_good_valid;
      ring_ptr_q[wr_idx_i]  <= wr_state_i.ring_ptr;
      fill_cnt_q[wr_idx_i]  <= wr_state_i.fill_cnt;
    end
  end

  // ring slots are only read once written, so they carry no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slots_q[wr_idx_i] <= wr_state_i.slots;
    end
  end

endmodule

@@ src/rom3_core.sv @@
// decision logic: range and jump checks, ring update and median of three
module rom3_core (
  input  rom3_pkg::in_t         item_i,
  input  logic                  chan_ok_i,
  input  logic [rom3_pkg::DistW-1:0] max_dist_i,
  input  logic [rom3_pkg::DistW-1:0] max_jump_i,
  input  rom3_pkg::chan_state_t cur_i,
  output rom3_pkg::chan_state_t nxt_o,
  output logic                  wr_en_o,
  output rom3_pkg::out_t        res_o
);

  logic [rom3_pkg::DistW-1:0] raw;
  logic [rom3_pkg::DistW-1:0] diff;
  logic [rom3_pkg::DistW-1:0] lo_ab;
  logic [rom3_pkg::DistW-1:0] hi_ab;
  logic [rom3_pkg::DistW-1:0] lo_hc;
  logic [rom3_pkg::DistW-1:0] median;
  logic [1:0]                 ptr;
  logic                       bad_range;
  logic                       bad_jump;
  rom3_pkg::ring_t            ring_new;

  always_comb begin
    raw       = item_i.raw_distance;
    bad_range = (raw == '0) || (raw > max_dist_i);
    diff      = (raw > cur_i.last_good) ? raw - cur_i.last_good : cur_i.last_good - raw;
    bad_jump  = cur_i.last_good_valid && (diff > max_jump_i);

    ptr = (cur_i.ring_ptr == 2'd3) ? 2'd0 : cur_i.ring_ptr;
    ring_new = cur_i.slots;
    ring_new[ptr] = raw;

    // median = max(min(a,b), min(max(a,b),c))
    lo_ab  = (ring_new[0] < ring_new[1]) ? ring_new[0] : ring_new[1];
    hi_ab  = (ring_new[0] < ring_new[1]) ? ring_new[1] : ring_new[0];
    lo_hc  = (hi_ab < ring_new[2]) ? hi_ab : ring_new[2];
    median = (lo_ab > lo_hc) ? lo_ab : lo_hc;

    nxt_o.last_good       = raw;
    nxt_o.last_good_valid = 1'b1;
    nxt_o.ring_ptr        = (ptr == 2'd2) ? 2'd0 : ptr + 2'd1;
    nxt_o.fill_cnt        = (cur_i.fill_cnt == 2'd3) ? 2'd3 : cur_i.fill_cnt + 2'd1;
    nxt_o.slots           = ring_new;

    wr_en_o                 = 1'b0;
    res_o.channel_out       = item_i.channel;
    res_o.filtered_distance = raw;
    res_o.status            = rom3_pkg::StFill;

    if (!chan_ok_i) begin
      // unknown channel behaves as one with no history
      res_o.status = bad_range ? rom3_pkg::StRange : rom3_pkg::StFill;
    end else if (bad_range) begin
      res_o.filtered_distance = cur_i.last_good_valid ? cur_i.last_good : raw;
      res_o.status            = rom3_pkg::StRange;
    end else if (bad_jump) begin
      res_o.filtered_distance = cur_i.last_good;
      res_o.status            = rom3_pkg::StJump;
    end else begin
      wr_en_o = 1'b1;
      if (cur_i.fill_cnt == 2'd3) begin
        res_o.filtered_distance = median;
        res_o.status            = rom3_pkg::StMedian;
      end
    end
  end

endmodule

@@ src/range_outlier_median3_filter.sv @@
// top level of the range outlier filter with per-channel median of three
//
// Each beat carries a channel and a raw distance in cm and yields exactly one result beat.
// A beat lands in an input register; in the next cycle the range check, jump check, ring
// update and three-input median are done in one combinational pass that reads and writes
// the per-channel history registers, and the result goes to an output register. One beat
// per cycle is sustained while the output does not stall; a beat for the same channel may
// follow directly, since history is written as the previous beat moves to the output
// register. A stall on the output holds the input register and then backs up the input.
// The user writes max_distance and max_jump through the cfg port only while no beat is in
// flight; the block itself does not enforce it.
module range_outlier_median3_filter #(
  parameter int unsigned NumChannels = rom3_pkg::NumChannelsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rom3_pkg::in_t                     in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rom3_pkg::out_t                    out_o,
  input  logic                              cfg_we_i,
  input  logic [rom3_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [rom3_pkg::DistW-1:0]        cfg_data_i
);

  localparam int unsigned IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  logic                       in_valid_q;
  rom3_pkg::in_t              in_q;
  logic                       out_valid_q;
  rom3_pkg::out_t             out_q;
  logic [rom3_pkg::DistW-1:0] max_dist_q;
  logic [rom3_pkg::DistW-1:0] max_jump_q;

  logic                       in_take;
  logic                       advance;
  logic                       chan_ok;
  logic [IdxW-1:0]            chan_idx;
  logic                       wr_en;
  rom3_pkg::chan_state_t      cur_state;
  rom3_pkg::chan_state_t      nxt_state;
  rom3_pkg::out_t             res;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign chan_ok  = ({{(32 - rom3_pkg::ChanW){1'b0}}, in_q.channel} < 32'(NumChannels));
  // unknown channels read entry zero, which the core ignores
  assign chan_idx = chan_ok ? IdxW'(in_q.channel) : '0;

  rom3_chan_state #(
    .NumChannels (NumChannels),
    .IdxW        (IdxW)
  ) u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (chan_idx),
    .rd_state_o (cur_state),
    .wr_en_i    (advance && wr_en),
    .wr_idx_i   (chan_idx),
    .wr_state_i (nxt_state)
  );

  rom3_core u_core (
    .item_i     (in_q),
    .chan_ok_i  (chan_ok),
    .max_dist_i (max_dist_q),
    .max_jump_i (max_jump_q),
    .cur_i      (cur_state),
    .nxt_o      (nxt_state),
    .wr_en_o    (wr_en),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      max_dist_q  <= rom3_pkg::MaxDistReset;
      max_jump_q  <= rom3_pkg::MaxJumpReset;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (rom3_pkg::cfg_reg_e'(cfg_idx_i))
          rom3_pkg::RegMaxDist: max_dist_q <= cfg_data_i;
          rom3_pkg::RegMaxJump: max_jump_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
